FILE: rtl/core/etc_pkg.sv
// Shared constants and types for the epoch to calendar date/time converter.
`timescale 1ns / 1ps
`default_nettype none

package etc_pkg;

  // Number of register stages from input to output.
  localparam int NStages = 8;

  // Per-stage load enables, stage 0 is the input stage.
  typedef logic [NStages-1:0] stage_en_t;

  // Seconds per day is 128 * 675; floor(2^32 / 675) estimates the day count.
  localparam logic [22:0] RecipDay675 = 23'd6362914;
  localparam logic [25:0] Day675      = 26'd675;
  localparam logic [10:0] Day675Rem   = 11'd675;

  // Time of day: hour = (tod >> 4) / 225, minute = (rem >> 2) / 15.
  localparam logic [13:0] RecipHour225 = 14'd9321;
  localparam logic [10:0] RecipMin15   = 11'd1093;
  localparam logic [11:0] SecsPerHour  = 12'd3600;
  localparam logic [5:0]  SecsPerMin   = 6'd60;

  // Civil date: shift to days since 0000-03-01 and split into eras.
  localparam logic [19:0] DayShift    = 20'd719468;
  localparam logic [19:0] Era4Start   = 20'd584388;
  localparam logic [19:0] Era5Start   = 20'd730485;
  localparam logic [17:0] DaysCent    = 18'd36524;
  localparam logic [17:0] DaysEraLast = 18'd146096;
  localparam logic [16:0] Recip365A   = 17'd91930;
  localparam logic [18:0] Recip365B   = 19'd367720;
  localparam logic [17:0] DaysPerYear = 18'd365;
  localparam logic [11:0] Recip153    = 12'd3427;
  localparam logic [11:0] Recip5      = 12'd3277;
  localparam logic [11:0] Era4Year    = 12'd1600;
  localparam logic [11:0] Era5Year    = 12'd2000;

endpackage

`default_nettype wire

FILE: rtl/core/etc_pipe_ctrl.sv
// Valid tracking and stall control for the converter pipeline.
`timescale 1ns / 1ps
`default_nettype none

module etc_pipe_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output etc_pkg::stage_en_t      stage_en
);

  etc_pkg::stage_en_t valid;

  // A stage loads when it is empty or the stage after it moves on.
  // Empty stages therefore fill up while the output waits.
  always_comb begin
    stage_en[etc_pkg::NStages-1] = !valid[etc_pkg::NStages-1] || out_ready;
    for (int k = etc_pkg::NStages - 2; k >= 0; k--) begin
      stage_en[k] = !valid[k] || stage_en[k+1];
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (stage_en[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < etc_pkg::NStages; k++) begin
        if (stage_en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign in_ready  = stage_en[0];
  assign out_valid = valid[etc_pkg::NStages-1];

endmodule

`default_nettype wire

FILE: rtl/core/etc_split.sv
// Splits a second count into whole days and seconds within the day.
`timescale 1ns / 1ps
`default_nettype none

module etc_split (
  input  wire logic          clk,
  input  wire logic          en_s1,
  input  wire logic          en_s2,
  input  wire logic [31:0]   epoch_seconds,
  output logic [15:0]        days,
  output logic [16:0]        tod,
  output logic               zero
);

  logic [47:0] est_prod;
  logic [31:0] secs1;
  logic [15:0] q_est;
  logic [25:0] q_times;
  logic [25:0] rem_wide;
  logic [10:0] rem_raw;
  logic        rem_over;
  logic [15:0] days_next;
  logic [9:0]  rem_fix;

  // Stage 1: estimate of (seconds >> 7) / 675, low by at most one.
  assign est_prod = {23'd0, epoch_seconds[31:7]} * {25'd0, etc_pkg::RecipDay675};

  always_ff @(posedge clk) begin
    if (en_s1) begin
      secs1 <= epoch_seconds;
      q_est <= est_prod[47:32];
    end
  end

  // Stage 2: remainder check and one correction step.
  assign q_times   = {10'd0, q_est} * etc_pkg::Day675;
  assign rem_wide  = {1'b0, secs1[31:7]} - q_times;
  assign rem_raw   = rem_wide[10:0];
  assign rem_over  = rem_raw >= etc_pkg::Day675Rem;
  assign days_next = rem_over ? q_est + 16'd1 : q_est;
  assign rem_fix   = rem_over ? 10'(rem_raw - etc_pkg::Day675Rem) : rem_raw[9:0];

  always_ff @(posedge clk) begin
    if (en_s2) begin
      days <= days_next;
      tod  <= {rem_fix, secs1[6:0]};
      zero <= secs1 == 32'd0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/etc_clock.sv
// Converts seconds within a day into hour, minute and second.
`timescale 1ns / 1ps
`default_nettype none

module etc_clock (
  input  wire logic          clk,
  input  wire logic          en_s3,
  input  wire logic          en_s4,
  input  wire logic          en_s5,
  input  wire logic          en_s6,
  input  wire logic          en_s7,
  input  wire logic          en_s8,
  input  wire logic [16:0]   tod,
  output logic [4:0]         hour,
  output logic [5:0]         minute,
  output logic [5:0]         second
);

  logic [26:0] hour_prod;
  logic [16:0] tod3;
  logic [4:0]  hour3, hour4, hour5, hour6, hour7;
  logic [16:0] hour_secs;
  logic [11:0] rem4, rem5;
  logic [20:0] min_prod;
  logic [5:0]  min5, min6, min7;
  logic [11:0] min_secs;
  logic [5:0]  sec6, sec7;

  // Stage 3: hour by reciprocal multiply, exact for this range.
  assign hour_prod = {14'd0, tod[16:4]} * {13'd0, etc_pkg::RecipHour225};

  always_ff @(posedge clk) begin
    if (en_s3) begin
      tod3  <= tod;
      hour3 <= hour_prod[25:21];
    end
  end

  // Stage 4: seconds left within the hour.
  assign hour_secs = {12'd0, hour3} * {5'd0, etc_pkg::SecsPerHour};

  always_ff @(posedge clk) begin
    if (en_s4) begin
      rem4  <= 12'(tod3 - hour_secs);
      hour4 <= hour3;
    end
  end

  // Stage 5: minute by reciprocal multiply.
  assign min_prod = {11'd0, rem4[11:2]} * {10'd0, etc_pkg::RecipMin15};

  always_ff @(posedge clk) begin
    if (en_s5) begin
      rem5  <= rem4;
      min5  <= min_prod[19:14];
      hour5 <= hour4;
    end
  end

  // Stage 6: seconds left within the minute.
  assign min_secs = {6'd0, min5} * {6'd0, etc_pkg::SecsPerMin};

  always_ff @(posedge clk) begin
    if (en_s6) begin
      sec6  <= 6'(rem5 - min_secs);
      min6  <= min5;
      hour6 <= hour5;
    end
  end

  // Stages 7 and 8: align with the date path.
  always_ff @(posedge clk) begin
    if (en_s7) begin
      sec7  <= sec6;
      min7  <= min6;
      hour7 <= hour6;
    end
    if (en_s8) begin
      second <= sec7;
      minute <= min7;
      hour   <= hour7;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/etc_civil.sv
// Converts a day count since 1970-01-01 into Gregorian year, month and day.
`timescale 1ns / 1ps
`default_nettype none

module etc_civil (
  input  wire logic          clk,
  input  wire logic          en_s3,
  input  wire logic          en_s4,
  input  wire logic          en_s5,
  input  wire logic          en_s6,
  input  wire logic          en_s7,
  input  wire logic          en_s8,
  input  wire logic [15:0]   days,
  input  wire logic          zero,
  output logic [11:0]        year,
  output logic [3:0]         month,
  output logic [4:0]         day,
  output logic               no_timestamp
);

  logic [19:0] z;
  logic        era_hi;
  logic [19:0] doe_wide;
  logic [17:0] doe3, doe4, doe5;
  logic        hi3, hi4, hi5, hi6, hi7;
  logic        zero3, zero4, zero5, zero6, zero7;
  logic [32:0] q1460_prod;
  logic [6:0]  q1460;
  logic [2:0]  q_cent;
  logic        q_last;
  logic [17:0] t4;
  logic [36:0] yoe_prod;
  logic [8:0]  yoe5, yoe6, yoe7;
  logic [17:0] yoe_days;
  logic [1:0]  yoe_cent;
  logic [17:0] year_start;
  logic [8:0]  doy6, doy7;
  logic [10:0] doy5x;
  logic [22:0] mp_prod;
  logic [3:0]  mp7;
  logic [10:0] month_base;
  logic [22:0] md_prod;
  logic [8:0]  md_days;
  logic [3:0]  mon;
  logic        early;
  logic [8:0]  day_wide;

  // Stage 3: days since 0000-03-01; only eras 4 and 5 are reachable.
  assign z        = {4'd0, days} + etc_pkg::DayShift;
  assign era_hi   = z >= etc_pkg::Era5Start;
  assign doe_wide = z - (era_hi ? etc_pkg::Era5Start : etc_pkg::Era4Start);

  always_ff @(posedge clk) begin
    if (en_s3) begin
      doe3  <= doe_wide[17:0];
      hi3   <= era_hi;
      zero3 <= zero;
    end
  end

  // Stage 4: leap-day corrections to the day of era.
  assign q1460_prod = {17'd0, doe3[17:2]} * {16'd0, etc_pkg::Recip365A};
  assign q1460      = q1460_prod[31:25];
  assign q_cent     = 3'(doe3 >= etc_pkg::DaysCent) + 3'(doe3 >= 18'd73048)
                    + 3'(doe3 >= 18'd109572) + 3'(doe3 >= etc_pkg::DaysEraLast);
  assign q_last     = doe3 == etc_pkg::DaysEraLast;

  always_ff @(posedge clk) begin
    if (en_s4) begin
      t4    <= doe3 - 18'(q1460) + 18'(q_cent) - 18'(q_last);
      doe4  <= doe3;
      hi4   <= hi3;
      zero4 <= zero3;
    end
  end

  // Stage 5: year of era is the corrected count divided by 365.
  assign yoe_prod = {19'd0, t4} * {18'd0, etc_pkg::Recip365B};

  always_ff @(posedge clk) begin
    if (en_s5) begin
      yoe5  <= yoe_prod[35:27];
      doe5  <= doe4;
      hi5   <= hi4;
      zero5 <= zero4;
    end
  end

  // Stage 6: day of the March-based year.
  assign yoe_days   = {9'd0, yoe5} * etc_pkg::DaysPerYear;
  assign yoe_cent   = 2'(yoe5 >= 9'd100) + 2'(yoe5 >= 9'd200) + 2'(yoe5 >= 9'd300);
  assign year_start = yoe_days + 18'(yoe5[8:2]) - 18'(yoe_cent);

  always_ff @(posedge clk) begin
    if (en_s6) begin
      doy6  <= 9'(doe5 - year_start);
      yoe6  <= yoe5;
      hi6   <= hi5;
      zero6 <= zero5;
    end
  end

  // Stage 7: March-based month index, (5 * doy + 2) / 153.
  assign doy5x   = 11'({doy6, 2'b00} + {2'b00, doy6} + 11'd2);
  assign mp_prod = {12'd0, doy5x} * {11'd0, etc_pkg::Recip153};

  always_ff @(posedge clk) begin
    if (en_s7) begin
      mp7   <= mp_prod[22:19];
      doy7  <= doy6;
      yoe7  <= yoe6;
      hi7   <= hi6;
      zero7 <= zero6;
    end
  end

  // Stage 8: day of month, calendar month and year.
  // 153 * mp is built as (128 + 16 + 8 + 1) * mp.
  assign month_base = {mp7, 7'd0} + {3'd0, mp7, 4'd0} + {4'd0, mp7, 3'd0}
                    + {7'd0, mp7} + 11'd2;
  assign md_prod    = {12'd0, month_base} * {11'd0, etc_pkg::Recip5};
  assign md_days    = md_prod[22:14];
  assign day_wide   = doy7 - md_days + 9'd1;
  assign mon        = (mp7 < 4'd10) ? mp7 + 4'd3 : mp7 - 4'd9;
  assign early      = mon <= 4'd2;

  always_ff @(posedge clk) begin
    if (en_s8) begin
      day          <= day_wide[4:0];
      month        <= mon;
      year         <= (hi7 ? etc_pkg::Era5Year : etc_pkg::Era4Year) + {3'd0, yoe7}
                    + {11'd0, early};
      no_timestamp <= zero7;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/epoch_to_calendar_datetime.sv
// Top level of the Unix epoch seconds to calendar date and time converter.
//
// Usage:
//   The input channel (in_valid, in_ready, epoch_seconds) carries one
//   unsigned 32-bit count of seconds since 1970-01-01 00:00:00 UTC per
//   transaction. The output channel (out_valid, out_ready) carries year,
//   month, day, hour, minute, second and no_timestamp for that input.
//   no_timestamp is set for a zero input; the date still reads 1970-01-01.
//   The converter is an eight-stage pipeline: a result is presented once
//   its input transaction has passed through all stage registers, and one
//   transaction is taken every cycle while the receiver keeps up.
//   The stage count comes from the date path, one reciprocal multiply or
//   compare-and-subtract step per stage in place of the divisions by
//   86400, 146097, 365, 153 and the like.
//   When the receiver stalls, the output holds its result and the earlier
//   stages keep filling any empty slots; in_ready drops only when every
//   stage holds a transaction. Results leave in input order.
//   Reset empties the pipeline; there is no other state.
`timescale 1ns / 1ps
`default_nettype none

module epoch_to_calendar_datetime (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [31:0]   epoch_seconds,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [11:0]        year,
  output logic [3:0]         month,
  output logic [4:0]         day,
  output logic [4:0]         hour,
  output logic [5:0]         minute,
  output logic [5:0]         second,
  output logic               no_timestamp
);

  etc_pkg::stage_en_t stage_en;
  logic [15:0]        days;
  logic [16:0]        tod;
  logic               zero;

  // Handshake and stall control.
  etc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stage_en  (stage_en)
  );

  // Days and time of day.
  etc_split u_split (
    .clk           (clk),
    .en_s1         (stage_en[0]),
    .en_s2         (stage_en[1]),
    .epoch_seconds (epoch_seconds),
    .days          (days),
    .tod           (tod),
    .zero          (zero)
  );

  // Hour, minute and second.
  etc_clock u_clock (
    .clk    (clk),
    .en_s3  (stage_en[2]),
    .en_s4  (stage_en[3]),
    .en_s5  (stage_en[4]),
    .en_s6  (stage_en[5]),
    .en_s7  (stage_en[6]),
    .en_s8  (stage_en[7]),
    .tod    (tod),
    .hour   (hour),
    .minute (minute),
    .second (second)
  );

  // Year, month and day.
  etc_civil u_civil (
    .clk          (clk),
    .en_s3        (stage_en[2]),
    .en_s4        (stage_en[3]),
    .en_s5        (stage_en[4]),
    .en_s6        (stage_en[5]),
    .en_s7        (stage_en[6]),
    .en_s8        (stage_en[7]),
    .days         (days),
    .zero         (zero),
    .year         (year),
    .month        (month),
    .day          (day),
    .no_timestamp (no_timestamp)
  );

`ifndef SYNTHESIS
  // An empty output stage never blocks the input.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while output stage is empty");

  // A zero timestamp must convert to the epoch itself.
  a_zero_is_epoch: assert property (@(posedge clk) disable iff (rst)
    (out_valid && no_timestamp) |-> (year == 12'd1970 && month == 4'd1 &&
      day == 5'd1 && hour == 5'd0 && minute == 6'd0 && second == 6'd0))
    else $error("zero timestamp did not convert to 1970-01-01 00:00:00");

  // Every result lies in the calendar and clock ranges.
  a_fields_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month >= 4'd1 && month <= 4'd12 && day >= 5'd1 &&
      hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59 &&
      year >= 12'd1970 && year <= 12'd2106))
    else $error("result field out of range");
`endif

endmodule

`default_nettype wire

FILE: bench/epoch_to_calendar_datetime_test.sv
// Self-checking bench for the epoch seconds to calendar date and time converter.
`timescale 1ns / 1ps

module epoch_to_calendar_datetime_test;

  // Expected calendar fields for one timestamp, kept with the input for messages.
  typedef struct packed {
    logic [31:0] epoch;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        no_timestamp;
  } datetime_t;

  // One timestamp waiting to be sent; drain_first holds it until all results are in.
  typedef struct {
    logic [31:0] epoch;
    bit          drain_first;
  } pending_t;

  localparam int RandomItems   = 1600;
  localparam int QuietTail     = 150;
  localparam int PipeLatency   = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] epoch_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic        no_timestamp;

  pending_t  pending_epochs[$];
  datetime_t expected_datetimes[$];
  datetime_t want;

  int total_items = 0;
  int directed_count = 0;
  int accepted_count = 0;
  int results_seen = 0;
  int zero_flags_seen = 0;
  int error_count = 0;
  int send_gap = 0;
  int sink_gap = 0;

  epoch_to_calendar_datetime dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .epoch_seconds (epoch_seconds),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .second        (second),
    .no_timestamp  (no_timestamp)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Civil date and time of a Unix timestamp, by days since 0000-03-01 split into eras.
  function automatic datetime_t civil_datetime_of(logic [31:0] secs);
    int unsigned days;
    int unsigned tod;
    int unsigned shifted;
    int unsigned era;
    int unsigned doe;
    int unsigned yoe;
    int unsigned doy;
    int unsigned mp;
    int unsigned mon;
    datetime_t   r;
    days    = secs / 86400;
    tod     = secs % 86400;
    shifted = days + 719468;
    era     = shifted / 146097;
    doe     = shifted - era * 146097;
    yoe     = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy     = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp      = (5 * doy + 2) / 153;
    mon     = (mp < 10) ? mp + 3 : mp - 9;
    r.epoch        = secs;
    r.day          = 5'(doy - (153 * mp + 2) / 5 + 1);
    r.month        = 4'(mon);
    r.year         = 12'(era * 400 + yoe + ((mon <= 2) ? 1 : 0));
    r.hour         = 5'(tod / 3600);
    r.minute       = 6'((tod % 3600) / 60);
    r.second       = 6'(tod % 60);
    r.no_timestamp = (secs == 32'd0);
    return r;
  endfunction

  // Random timestamp: full range, day and hour edges, random day and time, low and high ends.
  function automatic logic [31:0] random_epoch();
    int unsigned pick;
    int unsigned base;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: begin
        return $urandom;
      end
      4, 5: begin
        // Just around midnight of a random day.
        base = $urandom_range(1, 49710) * 86400;
        return base + $urandom_range(0, 4) - 2;
      end
      6: begin
        // Random day, random time of day.
        return $urandom_range(0, 49709) * 86400 + $urandom_range(0, 86399);
      end
      7: begin
        return $urandom_range(0, 200000);
      end
      8: begin
        return 32'hFFFF_FFFF - $urandom_range(0, 200000);
      end
      default: begin
        // Around a minute or hour boundary.
        base = $urandom_range(0, 1193045) * 3600;
        return base + $urandom_range(0, 120) - 60;
      end
    endcase
  endfunction

  // Idle bursts run outside the directed part, in two of every three spans, and not at the end.
  function automatic bit gaps_allowed(int n);
    return n >= directed_count && n + QuietTail < total_items && (n / 200) % 3 != 2;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report(string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val,
                             logic [31:0] epoch);
    if (got !== exp_val)
      report($sformatf("epoch %0d: %s is %0d, expected %0d", epoch, name, got, exp_val));
  endtask

  task automatic add_item(logic [31:0] epoch, bit drain_first);
    pending_t p;
    p.epoch       = epoch;
    p.drain_first = drain_first;
    pending_epochs.push_back(p);
  endtask

  // Input driver: presents queued timestamps and records a prediction per transaction.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_datetimes.push_back(civil_datetime_of(epoch_seconds));
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (gaps_allowed(accepted_count) && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else if (pending_epochs.size() > 0 &&
                     !(pending_epochs[0].drain_first && expected_datetimes.size() > 0)) begin
          epoch_seconds <= pending_epochs[0].epoch;
          in_valid <= 1'b1;
          pending_epochs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compares each result transaction with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_datetimes.size() == 0) begin
          report($sformatf("result %0d-%0d-%0d %0d:%0d:%0d with nothing expected",
                           year, month, day, hour, minute, second));
        end else begin
          want = expected_datetimes.pop_front();
          check_field("year", 32'(year), 32'(want.year), want.epoch);
          check_field("month", 32'(month), 32'(want.month), want.epoch);
          check_field("day", 32'(day), 32'(want.day), want.epoch);
          check_field("hour", 32'(hour), 32'(want.hour), want.epoch);
          check_field("minute", 32'(minute), 32'(want.minute), want.epoch);
          check_field("second", 32'(second), 32'(want.second), want.epoch);
          check_field("no_timestamp", 32'(no_timestamp), 32'(want.no_timestamp),
                      want.epoch);
          if (want.no_timestamp) zero_flags_seen++;
          results_seen++;
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        out_ready <= 1'b0;
      end else if (gaps_allowed(results_seen) && $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    // Zero input, time-of-day edges and the first day boundary.
    add_item(32'd0, 1'b0);
    add_item(32'd1, 1'b0);
    add_item(32'd59, 1'b0);
    add_item(32'd60, 1'b0);
    add_item(32'd3599, 1'b0);
    add_item(32'd3600, 1'b0);
    add_item(32'd86399, 1'b0);
    add_item(32'd86400, 1'b0);
    // End of the first year, first leap day, century leap day and the non-leap 2100.
    add_item(32'd31535999, 1'b0);
    add_item(32'd68169600, 1'b0);
    add_item(32'd946684799, 1'b0);
    add_item(32'd951782400, 1'b0);
    add_item(32'd951868800, 1'b0);
    add_item(32'd4107542399, 1'b0);
    add_item(32'd4107542400, 1'b0);
    // Sign-bit and top-of-range values, the largest giving 2106-02-07 06:28:15.
    add_item(32'h7FFF_FFFF, 1'b0);
    add_item(32'h8000_0000, 1'b0);
    add_item(32'hAAAA_AAAA, 1'b0);
    add_item(32'h5555_5555, 1'b0);
    add_item(32'hFFFF_FFFE, 1'b0);
    add_item(32'hFFFF_FFFF, 1'b0);
    add_item(32'd0, 1'b1);
    directed_count = pending_epochs.size();
    for (int i = 0; i < RandomItems; i++)
      add_item(random_epoch(), (i == RandomItems / 2) || (i == RandomItems - 300));
    total_items = pending_epochs.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < total_items || expected_datetimes.size() > 0)
      @(posedge clk);
    repeat (2 * PipeLatency) @(posedge clk);

    $display("tb: %0d timestamps converted and checked, %0d with the zero flag set",
             results_seen, zero_flags_seen);
    $display("tb: directed calendar edges, then random spans with stalls on both sides");
    if (error_count == 0 && expected_datetimes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
